/* hdl/heater_pid_duty_regulator_top_assert.svh */
// Assertion macros for the heater PID duty regulator checker.
// No dependencies; included by the checker file only.
`ifndef HEATER_PID_DUTY_REGULATOR_TOP_ASSERT_SVH
`define HEATER_PID_DUTY_REGULATOR_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HPDR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HPDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies a delayed consequent.
`define HPDR_ASSERT_DLY2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

/* hdl/hpdr_pkg.sv */
// Package for the heater PID duty regulator: field types and loop constants.
// No dependencies; used by the top level and by the checker.
package hpdr_pkg;

    // Field and internal value types.
    typedef logic        [10:0] temp_t;
    typedef logic        [6:0]  target_t;
    typedef logic        [9:0]  duty_t;
    typedef logic signed [12:0] err_t;
    typedef logic signed [11:0] rise_t;
    typedef logic signed [9:0]  slope_sum_t;
    typedef logic signed [7:0]  slope_t;
    typedef logic signed [13:0] integ_t;
    typedef logic signed [14:0] integ_acc_t;
    typedef logic signed [17:0] pid_t;

    // Setpoint after reset, in whole degrees.
    localparam target_t    TARGET_RESET  = 7'd50;

    // Error thresholds in tenths of a degree.
    localparam err_t       ERR_FULL_ON   = 13'sd50;
    localparam err_t       ERR_FULL_OFF  = -13'sd20;
    localparam err_t       ERR_INTEG_MAX = 13'sd20;

    // Per-sample rise is limited to this many tenths either way.
    localparam rise_t      RISE_LIMIT    = 12'sd20;

    // Integral clamp.
    localparam integ_acc_t INTEG_LIMIT   = 15'sd4000;

    // PID output offset and duty bounds.
    localparam pid_t       PID_BIAS      = 18'sd250;
    localparam pid_t       PID_DUTY_MAX  = 18'sd1000;
    localparam duty_t      DUTY_MAX      = 10'd1000;

endpackage

/* hdl/heater_pid_duty_regulator_top.sv */
// Heater PID duty regulator: temperature sample stream in, heater duty stream out.
// Depends on hpdr_pkg.
// A sample passes the input register, then the PID update into the duty register.
// Throughput: one sample per cycle while the duty stream is not stalled, since the
// integral, slope and last-sample registers are updated together with the duty register.
// Reset (aresetn low, synchronous): both stages empty, integral, slope, last sample and
// duty cleared, setpoint back to 50 degrees.
module heater_pid_duty_regulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Setpoint register write channel.
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [6:0]  cfg_wdata,      // target_degrees
    // Sample stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [10:0] temp_tenths, [15:11] zero
    input  logic [1:0]  s_tuser,        // [0] temp_valid, [1] restart
    // Duty stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata         // [9:0] duty_permille, [15:10] zero
);

    // Constant-coefficient PID sum: 250 + 14*err + integral/8 - 8*slope.
    function automatic hpdr_pkg::pid_t pid_calc(input hpdr_pkg::err_t e,
                                                input hpdr_pkg::integ_t i,
                                                input hpdr_pkg::slope_t s);
        hpdr_pkg::pid_t   e_ext;
        hpdr_pkg::pid_t   p_term;
        hpdr_pkg::integ_t i_adj;
        hpdr_pkg::integ_t i_div;
        hpdr_pkg::pid_t   i_term;
        hpdr_pkg::pid_t   d_term;
        e_ext  = {{5{e[12]}}, e};
        p_term = (e_ext <<< 4) - (e_ext <<< 1);
        // Bias negative values so the shift truncates toward zero.
        i_adj  = i[13] ? (i + 14'sd7) : i;
        i_div  = i_adj >>> 3;
        i_term = {{4{i_div[13]}}, i_div};
        d_term = {{10{s[7]}}, s} <<< 3;
        return hpdr_pkg::PID_BIAS + p_term + i_term - d_term;
    endfunction

    hpdr_pkg::target_t target_reg;

    logic              in_valid_reg;
    hpdr_pkg::temp_t   in_temp_reg;
    logic              in_tvld_reg;
    logic              in_rst_reg;

    logic              out_valid_reg;
    hpdr_pkg::integ_t  integral_reg, integral_next;
    hpdr_pkg::slope_t  slope_reg, slope_next;
    hpdr_pkg::temp_t   prev_temp_reg, prev_temp_next;
    hpdr_pkg::duty_t   held_duty_reg, held_duty_next;

    logic                 advance;
    logic                 restart_eff;
    hpdr_pkg::integ_t     integ_base;
    hpdr_pkg::slope_t     slope_base;
    hpdr_pkg::temp_t      prev_base;
    logic [10:0]          target_x10;
    hpdr_pkg::err_t       err;
    hpdr_pkg::rise_t      rise_raw;
    hpdr_pkg::rise_t      rise;
    hpdr_pkg::slope_sum_t slope_sum;
    hpdr_pkg::slope_sum_t slope_adj;
    hpdr_pkg::slope_sum_t slope_div;
    hpdr_pkg::slope_t     slope_new;
    hpdr_pkg::pid_t       pid_trial;
    hpdr_pkg::integ_acc_t integ_acc;
    hpdr_pkg::integ_t     integ_clamped;
    hpdr_pkg::pid_t       pid_final;
    hpdr_pkg::pid_t       pid_used;
    logic                 integrate;

    // Handshakes: the duty register moves when empty or taken, the input register follows.
    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || advance;
    assign cfg_wready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, held_duty_reg};

    // Restart clears the history before this sample's update.
    always_comb begin
        restart_eff = in_tvld_reg && in_rst_reg;
        integ_base  = restart_eff ? '0 : integral_reg;
        slope_base  = restart_eff ? '0 : slope_reg;
        prev_base   = restart_eff ? in_temp_reg : prev_temp_reg;
    end

    // Error and filtered slope.
    always_comb begin
        target_x10 = {1'b0, target_reg, 3'b000} + {3'b000, target_reg, 1'b0};
        err        = $signed({2'b00, target_x10}) - $signed({2'b00, in_temp_reg});
        rise_raw   = $signed({1'b0, in_temp_reg}) - $signed({1'b0, prev_base});
        if (rise_raw > hpdr_pkg::RISE_LIMIT) begin
            rise = hpdr_pkg::RISE_LIMIT;
        end else if (rise_raw < -hpdr_pkg::RISE_LIMIT) begin
            rise = -hpdr_pkg::RISE_LIMIT;
        end else begin
            rise = rise_raw;
        end
        slope_sum = ({{2{slope_base[7]}}, slope_base} <<< 1)
                  + {{2{slope_base[7]}}, slope_base}
                  + (rise[9:0] <<< 2);
        slope_adj = slope_sum[9] ? (slope_sum + 10'sd3) : slope_sum;
        slope_div = slope_adj >>> 2;
        slope_new = slope_div[7:0];
    end

    // PID with conditional integration and the integral clamp.
    always_comb begin
        pid_trial = pid_calc(err, integ_base, slope_new);
        integrate = (err <= hpdr_pkg::ERR_INTEG_MAX) && (pid_trial > 18'sd0)
                    && (pid_trial < hpdr_pkg::PID_DUTY_MAX);
        integ_acc = {integ_base[13], integ_base} + 15'(err);
        if (integ_acc > hpdr_pkg::INTEG_LIMIT) begin
            integ_clamped = hpdr_pkg::INTEG_LIMIT[13:0];
        end else if (integ_acc < -hpdr_pkg::INTEG_LIMIT) begin
            integ_clamped = 14'(-hpdr_pkg::INTEG_LIMIT);
        end else begin
            integ_clamped = integ_acc[13:0];
        end
        pid_final = pid_calc(err, integ_clamped, slope_new);
        pid_used  = integrate ? pid_final : pid_trial;
    end

    // Next state: full power, off, or the saturated PID output for a valid temperature; else held.
    always_comb begin
        integral_next  = integral_reg;
        slope_next     = slope_reg;
        prev_temp_next = prev_temp_reg;
        held_duty_next = held_duty_reg;
        if (in_tvld_reg) begin
            slope_next     = slope_new;
            prev_temp_next = in_temp_reg;
            if (err >= hpdr_pkg::ERR_FULL_ON) begin
                integral_next  = '0;
                held_duty_next = hpdr_pkg::DUTY_MAX;
            end else if (err <= hpdr_pkg::ERR_FULL_OFF) begin
                integral_next  = '0;
                held_duty_next = '0;
            end else begin
                integral_next = integrate ? integ_clamped : integ_base;
                if (pid_used < 18'sd0) begin
                    held_duty_next = '0;
                end else if (pid_used > hpdr_pkg::PID_DUTY_MAX) begin
                    held_duty_next = hpdr_pkg::DUTY_MAX;
                end else begin
                    held_duty_next = pid_used[9:0];
                end
            end
        end
    end

    // Setpoint register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= hpdr_pkg::TARGET_RESET;
        end else if (cfg_wvalid && cfg_wready) begin
            target_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_temp_reg <= s_tdata[10:0];
            in_tvld_reg <= s_tuser[0];
            in_rst_reg  <= s_tuser[1];
        end
    end

    // Loop state and duty register, updated when a sample moves to the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            slope_reg     <= '0;
            prev_temp_reg <= '0;
            held_duty_reg <= '0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                integral_reg  <= integral_next;
                slope_reg     <= slope_next;
                prev_temp_reg <= prev_temp_next;
                held_duty_reg <= held_duty_next;
            end
        end
    end

endmodule

/* hdl/hpdr_checker.sv */
// Port-level checker for the heater PID duty regulator, bound to the top level.
// Depends on hpdr_pkg and heater_pid_duty_regulator_top_assert.svh.
`include "heater_pid_duty_regulator_top_assert.svh"

module hpdr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled duty transaction keeps its value.
    `HPDR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "duty changed while stalled")

    // Every duty lies within 0..1000 with the pad bits clear.
    `HPDR_ASSERT_SAME(a_duty_range, aclk, aresetn, m_tvalid, (m_tdata[9:0] <= hpdr_pkg::DUTY_MAX) && (m_tdata[15:10] == 6'd0), "duty out of range")

    // An empty output stage never blocks the sample stream.
    `HPDR_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with output empty")

    // A sample transaction is followed by a valid duty output, checked after the input and duty registers.
    `HPDR_ASSERT_DLY2(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "no result after sample")

endmodule

bind heater_pid_duty_regulator_top hpdr_checker u_hpdr_checker (.*);
